[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define V2C_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("v2c checker: property failed");

// Same, on the block's own clk_i / rst_ni.
`define V2C_ASSERT(lbl, prop) `V2C_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`endif

[rtl/core/v2c_pkg.sv]
// Shared constants, types and helper functions of the 2-D correlation block.
// Depends on nothing; the interfaces, the MAC, the top level and the checker import it.
package v2c_pkg;

  localparam int unsigned MAX_K       = 5;
  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_HEIGHT  = 256;

  localparam int unsigned SumW     = 40;
  localparam int unsigned ProdW    = 2 * SAMPLE_BITS;
  localparam int unsigned OutIdxW  = 8;
  localparam int unsigned WidthW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HeightW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ColW     = $clog2(MAX_WIDTH);
  localparam int unsigned RowW     = $clog2(MAX_HEIGHT);
  localparam int unsigned KDimW    = 3;
  localparam int unsigned KTaps    = MAX_K * MAX_K;
  localparam int unsigned KIdxW    = (KTaps > 1) ? $clog2(KTaps + 1) : 1;
  localparam int unsigned SlotW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned WrapW    = $clog2(2 * MAX_K + 1);
  localparam int unsigned LineDepth = MAX_K * MAX_WIDTH;
  localparam int unsigned LineAddrW = $clog2(LineDepth);
  localparam int unsigned KAddrW    = (KTaps > 1) ? $clog2(KTaps) : 1;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = (WidthW > HeightW) ? WidthW : HeightW;

  typedef enum logic {
    CmdKernel = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegKRows  = 2'd2,
    RegKCols  = 2'd3
  } reg_idx_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

  function automatic logic [WidthW-1:0] clamp_width(logic [CfgDataW-1:0] v);
    logic [WidthW-1:0] r;
    if (v[WidthW-1:0] == '0) begin
      r = WidthW'(1);
    end else if (v[WidthW-1:0] > WidthW'(MAX_WIDTH)) begin
      r = WidthW'(MAX_WIDTH);
    end else begin
      r = v[WidthW-1:0];
    end
    return r;
  endfunction

  function automatic logic [HeightW-1:0] clamp_height(logic [CfgDataW-1:0] v);
    logic [HeightW-1:0] r;
    if (v[HeightW-1:0] == '0) begin
      r = HeightW'(1);
    end else if (v[HeightW-1:0] > HeightW'(MAX_HEIGHT)) begin
      r = HeightW'(MAX_HEIGHT);
    end else begin
      r = v[HeightW-1:0];
    end
    return r;
  endfunction

  function automatic logic [KDimW-1:0] clamp_kdim(logic [CfgDataW-1:0] v);
    logic [KDimW-1:0] r;
    if (v[KDimW-1:0] == '0) begin
      r = KDimW'(1);
    end else if (v[KDimW-1:0] > KDimW'(MAX_K)) begin
      r = KDimW'(MAX_K);
    end else begin
      r = v[KDimW-1:0];
    end
    return r;
  endfunction

  // Line store address: one row of MAX_WIDTH entries per slot.
  function automatic logic [LineAddrW-1:0] line_addr(logic [SlotW-1:0] slot,
                                                     logic [ColW-1:0] col);
    return LineAddrW'(slot) * LineAddrW'(MAX_WIDTH) + LineAddrW'(col);
  endfunction

endpackage

[rtl/core/v2c_stream_if.sv]
// Valid/ready channel interfaces for input words and result words.
// Depends on v2c_pkg for payload widths.
interface v2c_in_if import v2c_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

interface v2c_out_if import v2c_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SumW-1:0]   sum;
  logic [OutIdxW-1:0]       out_row;
  logic [OutIdxW-1:0]       out_col;
  logic                     frame_last;

  modport source (output valid, sum, out_row, out_col, frame_last, input ready);
  modport sink   (input valid, sum, out_row, out_col, frame_last, output ready);
endinterface

[rtl/core/v2c_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module v2c_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/v2c_mac.sv]
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on v2c_pkg.
module v2c_mac import v2c_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] a_i,
  input  logic signed [SAMPLE_BITS-1:0] b_i,
  output logic signed [SumW-1:0]        acc_o,
  output logic                          busy_o
);

  logic signed [ProdW-1:0] prod_q;
  logic                    pv_q;
  logic signed [SumW-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + {{(SumW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = pv_q;

endmodule

[rtl/core/valid_2d_convolution_unit.sv]
// Streaming 2-D valid cross-correlation (no kernel flip). A kernel word
// (command 0) is stored in the kernel RAM; an image word (command 1) is
// written into a ring of MAX_K line stores, and when it closes a
// kernel_rows x kernel_cols window the block walks that window through one
// shared multiply-accumulate unit, one product per cycle, fed by the single
// read port of the line RAM and the kernel RAM. Input ready therefore drops
// after such a word and stays low until the walk has drained and its result
// is loaded into the output register, which waits while an earlier result
// is still held there. The result sits in an output register so the next
// word can be taken while it waits. Any register write restarts the frame
// and the kernel load index; stored data is kept.
// Depends on v2c_pkg, v2c_stream_if, v2c_ram and v2c_mac.
module valid_2d_convolution_unit import v2c_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  v2c_in_if.sink              in_i,
  v2c_out_if.source           out_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain
  } state_e;

  state_e state_q;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [KDimW-1:0]   krows_q;
  logic [KDimW-1:0]   kcols_q;

  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic [SlotW-1:0]   slot_q;
  logic [KIdxW-1:0]   kload_q;

  logic [RowW-1:0]    r0_q;
  logic [ColW-1:0]    c0_q;
  logic               last_q;
  logic [KDimW-1:0]   ki_q;
  logic [KDimW-1:0]   kj_q;
  logic [KIdxW-1:0]   kidx_q;
  logic [SlotW-1:0]   lslot_q;
  logic [ColW-1:0]    rcol_q;
  logic               rd_valid_q;

  logic                    out_valid_q;
  logic signed [SumW-1:0]  out_sum_q;
  logic [OutIdxW-1:0]      out_row_q;
  logic [OutIdxW-1:0]      out_col_q;
  logic                    out_last_q;

  logic                    in_fire;
  logic                    is_sample;
  logic [WidthW-1:0]       col_next;
  logic [HeightW-1:0]      row_next;
  logic                    col_end;
  logic                    row_end;
  logic                    win_ok;
  logic [KIdxW-1:0]        n_taps;
  logic [KIdxW-1:0]        kload_inc;
  logic [WrapW-1:0]        lr0_raw;
  logic [SlotW-1:0]        lr0;
  logic [SlotW-1:0]        slot_inc;
  logic [SlotW-1:0]        lslot_inc;
  logic                    kj_last;
  logic                    ki_last;
  logic                    mac_done;
  logic                    out_load;

  logic                          line_we;
  logic                          kern_we;
  logic signed [SAMPLE_BITS-1:0] line_rdata;
  logic signed [SAMPLE_BITS-1:0] kern_rdata;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SumW-1:0]        acc;
  logic                          mac_busy;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_sample  = (in_i.command == CmdSample);

  assign col_next = WidthW'(col_q) + WidthW'(1);
  assign row_next = HeightW'(row_q) + HeightW'(1);
  assign col_end  = (col_next == width_q);
  assign row_end  = (row_next == height_q);
  assign win_ok   = (row_next >= HeightW'(krows_q)) && (col_next >= WidthW'(kcols_q));

  assign n_taps    = KIdxW'(krows_q) * KIdxW'(kcols_q);
  assign kload_inc = kload_q + KIdxW'(1);

  // Ring slot of the window's top row: slot + 1 - krows, modulo MAX_K.
  always_comb begin
    lr0_raw = WrapW'(slot_q) + WrapW'(MAX_K + 1) - WrapW'(krows_q);
    if (lr0_raw >= WrapW'(MAX_K)) begin
      lr0_raw = lr0_raw - WrapW'(MAX_K);
    end
    lr0 = lr0_raw[SlotW-1:0];
  end

  assign slot_inc  = (slot_q == SlotW'(MAX_K - 1)) ? '0 : slot_q + SlotW'(1);
  assign lslot_inc = (lslot_q == SlotW'(MAX_K - 1)) ? '0 : lslot_q + SlotW'(1);
  assign kj_last   = (kj_q == kcols_q - KDimW'(1));
  assign ki_last   = (ki_q == krows_q - KDimW'(1));

  assign mac_done = (state_q == StDrain) && !rd_valid_q && !mac_busy;
  assign out_load = mac_done && (!out_valid_q || out_o.ready);

  assign line_we = in_fire && is_sample;
  assign kern_we = in_fire && !is_sample;

  assign mac_ctrl.clear = line_we && win_ok;
  assign mac_ctrl.valid = rd_valid_q;

  v2c_ram #(
    .Width (SAMPLE_BITS),
    .Depth (LineDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_addr(slot_q, col_q)),
    .wdata_i (in_i.sample),
    .raddr_i (line_addr(lslot_q, rcol_q)),
    .rdata_o (line_rdata)
  );

  v2c_ram #(
    .Width (SAMPLE_BITS),
    .Depth (KTaps)
  ) u_kern_ram (
    .clk_i   (clk_i),
    .we_i    (kern_we),
    .waddr_i (kload_q[KAddrW-1:0]),
    .wdata_i (in_i.sample),
    .raddr_i (kidx_q[KAddrW-1:0]),
    .rdata_o (kern_rdata)
  );

  v2c_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (line_rdata),
    .b_i    (kern_rdata),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      width_q     <= WidthW'(32);
      height_q    <= HeightW'(32);
      krows_q     <= KDimW'(3);
      kcols_q     <= KDimW'(3);
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      kload_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= (state_q == StRun);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWidth:  width_q  <= clamp_width(cfg_data_i);
          RegHeight: height_q <= clamp_height(cfg_data_i);
          RegKRows:  krows_q  <= clamp_kdim(cfg_data_i);
          RegKCols:  kcols_q  <= clamp_kdim(cfg_data_i);
          default: ;
        endcase
        col_q   <= '0;
        row_q   <= '0;
        slot_q  <= '0;
        kload_q <= '0;
      end

      case (state_q)
        StIdle: begin
          if (kern_we) begin
            kload_q <= (kload_inc >= n_taps) ? '0 : kload_inc;
          end else if (line_we) begin
            r0_q    <= RowW'(row_next - HeightW'(krows_q));
            c0_q    <= ColW'(col_next - WidthW'(kcols_q));
            last_q  <= row_end && col_end;
            ki_q    <= '0;
            kj_q    <= '0;
            kidx_q  <= '0;
            lslot_q <= lr0;
            rcol_q  <= ColW'(col_next - WidthW'(kcols_q));
            if (win_ok) begin
              state_q <= StRun;
            end
            // Advance the frame position.
            if (col_end) begin
              col_q <= '0;
              if (row_end) begin
                row_q  <= '0;
                slot_q <= '0;
              end else begin
                row_q  <= row_q + RowW'(1);
                slot_q <= slot_inc;
              end
            end else begin
              col_q <= col_q + ColW'(1);
            end
          end
        end
        StRun: begin
          kidx_q <= kidx_q + KIdxW'(1);
          if (kj_last) begin
            kj_q    <= '0;
            rcol_q  <= c0_q;
            ki_q    <= ki_q + KDimW'(1);
            lslot_q <= lslot_inc;
            if (ki_last) begin
              state_q <= StDrain;
            end
          end else begin
            kj_q   <= kj_q + KDimW'(1);
            rcol_q <= rcol_q + ColW'(1);
          end
        end
        StDrain: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      // Hold the result until taken; a new one may replace it on the take.
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_sum_q   <= acc;
        out_row_q   <= OutIdxW'(r0_q);
        out_col_q   <= OutIdxW'(c0_q);
        out_last_q  <= last_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sum        = out_sum_q;
  assign out_o.out_row    = out_row_q;
  assign out_o.out_col    = out_col_q;
  assign out_o.frame_last = out_last_q;

endmodule

[rtl/core/v2c_checker.sv]
// Port-level checker for valid_2d_convolution_unit, bound to the top level.
// Depends on v2c_pkg and assert_macros.svh.
`include "assert_macros.svh"

module v2c_checker import v2c_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_command_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [SumW-1:0]    out_sum_i,
  input logic [OutIdxW-1:0] out_row_i,
  input logic [OutIdxW-1:0] out_col_i,
  input logic               out_last_i
);

  // A stalled result word holds.
  `V2C_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i) && $stable(out_row_i) && $stable(out_col_i) && $stable(out_last_i))

  // A kernel word never stalls the input.
  `V2C_ASSERT(a_kernel_quick, in_valid_i && in_ready_i && (in_command_i == CmdKernel) |=> in_ready_i)

  // A new result only comes out of a window walk, while input is held off.
  `V2C_ASSERT(a_result_from_walk, $rose(out_valid_i) |-> !$past(in_ready_i))

  // No result rises right after a sample word: the window walk lies between.
  `V2C_ASSERT(a_no_instant_result, in_valid_i && in_ready_i && (in_command_i == CmdSample) |=> !$rose(out_valid_i))

endmodule

bind valid_2d_convolution_unit v2c_checker u_v2c_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sum_i    (out_o.sum),
  .out_row_i    (out_o.out_row),
  .out_col_i    (out_o.out_col),
  .out_last_i   (out_o.frame_last)
);
